@@ rtl/pmt_pkg.sv @@
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types, constants and helpers for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package pmt_pkg;

    localparam int PMT_COORD_BITS = 12;   // default cursor coordinate width
    localparam int PMT_CFG_W      = 13;   // widest configuration register
    localparam int PMT_BTN_W      = 5;
    localparam int PMT_DELTA_W    = 10;   // covers -511 .. 510
    localparam int PMT_Q_DEPTH    = 2;    // packet queue between front and back

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_MODE   = 2'd0;
    localparam logic [1:0] CFG_IDX_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IDX_HEIGHT = 2'd2;

    localparam logic                 CFG_RST_MODE   = 1'b0;
    localparam logic [PMT_CFG_W-1:0] CFG_RST_WIDTH  = 13'd1024;
    localparam logic [PMT_CFG_W-1:0] CFG_RST_HEIGHT = 13'd768;

    // decoded packet handed from the front to the back
    typedef struct packed {
        logic [PMT_BTN_W-1:0]          buttons;
        logic signed [PMT_DELTA_W-1:0] dx;
        logic signed [PMT_DELTA_W-1:0] dy;
    } t_pkt;

    // 9-bit two's-complement delta; overflow adds 255 in the sign's direction
    function automatic logic signed [PMT_DELTA_W-1:0] axis_delta(
        input logic [7:0] data,
        input logic       neg,
        input logic       ovf
    );
        logic signed [PMT_DELTA_W-1:0] d;
        d = $signed({2'b00, data});
        if (neg) begin
            d = d - 10'sd256;
        end
        if (ovf) begin
            d = neg ? (d - 10'sd255) : (d + 10'sd255);
        end
        return d;
    endfunction

endpackage

@@ rtl/pmt_front.sv @@
// ----------------------------------------------------------------------------
// pmt_front
// Byte framing: sync on bit 3 of the first byte, collect 3 or 4 bytes and
// push one decoded packet into the queue.
// ----------------------------------------------------------------------------
module pmt_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_four_byte_mode,
    input  logic         i_rx_valid,
    output logic         o_rx_ready,
    input  logic [7:0]   i_rx_byte,
    input  logic         i_q_full,
    output logic         o_q_push,
    output pmt_pkg::t_pkt o_q_pkt
);
    import pmt_pkg::*;

    logic [1:0] r_cnt;
    logic [7:0] r_held0, r_held1, r_held2;
    logic [1:0] w_last;
    logic       w_accept;
    logic       w_drop;
    logic       w_done;
    logic [7:0] w_p2, w_p3;

    assign o_rx_ready = !i_q_full;
    assign w_accept   = i_rx_valid && o_rx_ready;
    assign w_last     = i_four_byte_mode ? 2'd3 : 2'd2;
    assign w_drop     = (r_cnt == 2'd0) && !i_rx_byte[3];
    // a mode change mid-packet may leave the count at or past the last slot
    assign w_done     = !w_drop && (r_cnt >= w_last);

    assign w_p2 = i_four_byte_mode ? r_held2 : i_rx_byte;
    assign w_p3 = i_four_byte_mode ? i_rx_byte : 8'h00;

    assign o_q_push        = w_accept && w_done;
    assign o_q_pkt.buttons = {w_p3[5], w_p3[4], r_held0[2:0]};
    assign o_q_pkt.dx      = axis_delta(r_held1, r_held0[4], r_held0[6]);
    assign o_q_pkt.dy      = axis_delta(w_p2, r_held0[5], r_held0[7]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_accept && !w_drop) begin
            r_cnt <= w_done ? 2'd0 : r_cnt + 2'd1;
        end
    end

    // held bytes: no reset, only read once written
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_drop && !w_done) begin
            case (r_cnt)
                2'd0:    r_held0 <= i_rx_byte;
                2'd1:    r_held1 <= i_rx_byte;
                2'd2:    r_held2 <= i_rx_byte;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/pmt_queue.sv @@
// ----------------------------------------------------------------------------
// pmt_queue
// Small packet FIFO between the framing front and the position back end.
// ----------------------------------------------------------------------------
module pmt_queue #(
    parameter int DEPTH = pmt_pkg::PMT_Q_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pmt_pkg::t_pkt i_pkt,
    input  logic          i_pop,
    output pmt_pkg::t_pkt o_pkt,
    output logic          o_full,
    output logic          o_empty
);
    import pmt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_pkt             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_pkt   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/pmt_back.sv @@
// ----------------------------------------------------------------------------
// pmt_back
// Cursor position update with clamping, and the registered result stage.
// ----------------------------------------------------------------------------
module pmt_back #(
    parameter int COORD_BITS = pmt_pkg::PMT_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pmt_pkg::PMT_CFG_W-1:0] i_screen_width,
    input  logic [pmt_pkg::PMT_CFG_W-1:0] i_screen_height,
    input  logic                          i_q_empty,
    input  pmt_pkg::t_pkt                 i_q_pkt,
    output logic                          o_q_pop,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [COORD_BITS-1:0]         o_cursor_x,
    output logic [COORD_BITS-1:0]         o_cursor_y,
    output logic [COORD_BITS-1:0]         o_prev_x,
    output logic [COORD_BITS-1:0]         o_prev_y,
    output logic [pmt_pkg::PMT_BTN_W-1:0] o_button_bits
);
    import pmt_pkg::*;

    // wide enough for position +/- 511 and for any screen limit
    localparam int SUM_W = ((COORD_BITS > PMT_CFG_W) ? COORD_BITS : PMT_CFG_W) + 2;
    localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'((1 << COORD_BITS) - 1);

    logic [COORD_BITS-1:0]   r_pos_x, r_pos_y;
    logic                    r_first_done;
    logic                    r_valid;
    logic signed [SUM_W-1:0] w_sum_x, w_sum_y;
    logic signed [SUM_W-1:0] w_lim_x, w_lim_y;
    logic [COORD_BITS-1:0]   n_pos_x, n_pos_y;

    // size 0 acts as 1; limit capped to the coordinate range
    function automatic logic signed [SUM_W-1:0] screen_limit(
        input logic [PMT_CFG_W-1:0] size
    );
        logic signed [SUM_W-1:0] lim;
        lim = (size == '0) ? '0 : $signed(SUM_W'(size - 1'b1));
        return (lim > COORD_MAX) ? COORD_MAX : lim;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp(
        input logic signed [SUM_W-1:0] v,
        input logic signed [SUM_W-1:0] lim
    );
        logic signed [SUM_W-1:0] c;
        c = (v < 0) ? '0 : ((v > lim) ? lim : v);
        return c[COORD_BITS-1:0];
    endfunction

    assign o_q_pop = !i_q_empty && (!r_valid || i_res_ready);
    assign o_res_valid = r_valid;

    assign w_lim_x = screen_limit(i_screen_width);
    assign w_lim_y = screen_limit(i_screen_height);
    assign w_sum_x = $signed(SUM_W'(r_pos_x)) + SUM_W'(i_q_pkt.dx);
    assign w_sum_y = $signed(SUM_W'(r_pos_y)) - SUM_W'(i_q_pkt.dy);

    always_comb begin
        if (r_first_done) begin
            n_pos_x = clamp(w_sum_x, w_lim_x);
            n_pos_y = clamp(w_sum_y, w_lim_y);
        end else begin
            n_pos_x = '0;
            n_pos_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_first_done <= 1'b0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
        end else begin
            if (o_q_pop) begin
                r_valid      <= 1'b1;
                r_first_done <= 1'b1;
                r_pos_x      <= n_pos_x;
                r_pos_y      <= n_pos_y;
            end else if (i_res_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            o_cursor_x    <= n_pos_x;
            o_cursor_y    <= n_pos_y;
            o_prev_x      <= r_pos_x;
            o_prev_y      <= r_pos_y;
            o_button_bits <= i_q_pkt.buttons;
        end
    end

endmodule

@@ rtl/ps2_mouse_packet_tracker.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// PS/2 mouse byte framing, packet decode and clamped cursor tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one mouse byte
//   per transfer, one transfer per cycle unless the queue is full. A packet
//   starts only with a byte that has bit 3 set; other leading bytes are
//   dropped silently. Three bytes make a packet, or four with four_byte_mode set.
//   Output channel (o_res_valid / i_res_ready) gives one result per packet:
//   new cursor X/Y, the previous X/Y and five button bits.
//   The byte that completes a packet is registered into the packet queue,
//   then into the position/result register before it shows up as a result.
//   Throughput: one byte per cycle, one result per cycle; the 2-entry queue
//   plus the result register let the output stall without blocking input
//   until the queue fills, after which o_rx_ready drops.
//   Reset (synchronous, active low) clears the framing count, the queue, the
//   result valid and the position; the first packet afterward forces 0,0.
//   Configuration: i_cfg_we writes register i_cfg_idx (0 mode, 1 width,
//   2 height) with no wait; write only while the block is idle.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker #(
    parameter int COORD_BITS = pmt_pkg::PMT_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [pmt_pkg::PMT_CFG_W-1:0] i_cfg_data,
    input  logic                          i_rx_valid,
    output logic                          o_rx_ready,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [COORD_BITS-1:0]         o_cursor_x,
    output logic [COORD_BITS-1:0]         o_cursor_y,
    output logic [COORD_BITS-1:0]         o_prev_x,
    output logic [COORD_BITS-1:0]         o_prev_y,
    output logic [pmt_pkg::PMT_BTN_W-1:0] o_button_bits
);
    import pmt_pkg::*;

    logic                 r_four_byte_mode;
    logic [PMT_CFG_W-1:0] r_screen_width;
    logic [PMT_CFG_W-1:0] r_screen_height;

    logic w_push, w_pop, w_full, w_empty;
    t_pkt w_push_pkt, w_pop_pkt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_byte_mode <= CFG_RST_MODE;
            r_screen_width   <= CFG_RST_WIDTH;
            r_screen_height  <= CFG_RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_MODE:   r_four_byte_mode <= i_cfg_data[0];
                CFG_IDX_WIDTH:  r_screen_width   <= i_cfg_data;
                CFG_IDX_HEIGHT: r_screen_height  <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // front: framing and delta decode
    pmt_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_four_byte_mode (r_four_byte_mode),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .i_q_full         (w_full),
        .o_q_push         (w_push),
        .o_q_pkt          (w_push_pkt)
    );

    pmt_queue #(
        .DEPTH (PMT_Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_push_pkt),
        .i_pop   (w_pop),
        .o_pkt   (w_pop_pkt),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // back: position update, clamp, result register
    pmt_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .i_q_empty       (w_empty),
        .i_q_pkt         (w_pop_pkt),
        .o_q_pop         (w_pop),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_cursor_x      (o_cursor_x),
        .o_cursor_y      (o_cursor_y),
        .o_prev_x        (o_prev_x),
        .o_prev_y        (o_prev_y),
        .o_button_bits   (o_button_bits)
    );

`ifndef SYNTHESIS
    // a finished packet must always find room in the queue
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("packet pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("packet popped from empty queue");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_full && w_empty))
        else $error("queue full and empty at once");

    // a popped packet always lands in the result register
    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_res_valid)
        else $error("popped packet produced no result");
`endif

endmodule
